>>> hdl/tkc_pkg.sv
// Shared types, constants and register codes for the touch key controller.
package tkc_pkg;

    localparam int KEY_SLOTS  = 4;
    localparam int KEY_W      = 2;
    localparam int COUNT_W    = 16;
    localparam int THR_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int LEVEL_W    = 3;
    localparam int LIDX_W     = 2;
    localparam int DUTY_W     = 8;
    localparam int TABLE_W    = 32;
    localparam int LEVELS     = 4;
    localparam int LED_W      = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam int KEYS_DEFAULT        = 4;
    localparam int CAL_SAMPLES_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT  = 16;

    localparam logic [THR_W-1:0]   THR_RESET   = 8'd15;
    localparam logic [HOLD_W-1:0]  SHORT_RESET = 16'd20;
    localparam logic [HOLD_W-1:0]  LONG_RESET  = 16'd500;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd4;
    localparam logic [TABLE_W-1:0] TABLE_RESET = 32'hFF641400;

    localparam int KEY_MOMENTARY = 0;
    localparam int KEY_TOGGLE    = 1;
    localparam int KEY_TIMER     = 2;
    localparam int KEY_DIMMER    = 3;

    // result tdata bit positions
    localparam int OUT_MOM      = 0;
    localparam int OUT_TOGGLE   = 1;
    localparam int OUT_TIMER    = 2;
    localparam int OUT_DUTY_LSB = 3;
    localparam int OUT_CAL      = 11;
    localparam int OUT_TOUCH    = 12;

    typedef enum logic [2:0] {
        REG_THR0,
        REG_THR1,
        REG_THR2,
        REG_THR3,
        REG_SHORT_HOLD,
        REG_LONG_HOLD,
        REG_LEVEL_COUNT,
        REG_DUTY_TABLE
    } reg_idx_t;

    typedef struct packed {
        logic [KEY_SLOTS-1:0][THR_W-1:0] threshold;
        logic [HOLD_W-1:0]               short_hold;
        logic [HOLD_W-1:0]               long_hold;
        logic [LEVEL_W-1:0]              level_count;
        logic [TABLE_W-1:0]              duty_table;
    } tkc_cfg_t;

    typedef struct packed {
        logic cal;
        logic touch;
        logic idle;
    } tkc_lane_t;

endpackage

>>> hdl/tkc_regs.sv
// APB configuration registers of the touch key controller.
module tkc_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tkc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tkc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tkc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output tkc_pkg::tkc_cfg_t               cfg
);
    import tkc_pkg::*;

    tkc_cfg_t cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_THR0:        cfg_next.threshold[0] = pwdata[THR_W-1:0];
                REG_THR1:        cfg_next.threshold[1] = pwdata[THR_W-1:0];
                REG_THR2:        cfg_next.threshold[2] = pwdata[THR_W-1:0];
                REG_THR3:        cfg_next.threshold[3] = pwdata[THR_W-1:0];
                REG_SHORT_HOLD:  cfg_next.short_hold   = pwdata[HOLD_W-1:0];
                REG_LONG_HOLD:   cfg_next.long_hold    = pwdata[HOLD_W-1:0];
                REG_LEVEL_COUNT: cfg_next.level_count  = pwdata[LEVEL_W-1:0];
                REG_DUTY_TABLE:  cfg_next.duty_table   = pwdata[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THR0:        prdata = APB_DATA_W'(cfg_reg.threshold[0]);
            REG_THR1:        prdata = APB_DATA_W'(cfg_reg.threshold[1]);
            REG_THR2:        prdata = APB_DATA_W'(cfg_reg.threshold[2]);
            REG_THR3:        prdata = APB_DATA_W'(cfg_reg.threshold[3]);
            REG_SHORT_HOLD:  prdata = APB_DATA_W'(cfg_reg.short_hold);
            REG_LONG_HOLD:   prdata = APB_DATA_W'(cfg_reg.long_hold);
            REG_LEVEL_COUNT: prdata = APB_DATA_W'(cfg_reg.level_count);
            REG_DUTY_TABLE:  prdata = APB_DATA_W'(cfg_reg.duty_table);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold   <= {KEY_SLOTS{THR_RESET}};
            cfg_reg.short_hold  <= SHORT_RESET;
            cfg_reg.long_hold   <= LONG_RESET;
            cfg_reg.level_count <= LEVEL_RESET;
            cfg_reg.duty_table  <= TABLE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/tkc_lane.sv
// One key lane: baseline calibration, touch compare and hold counter.
module tkc_lane #(
    parameter int CAL_SAMPLES = tkc_pkg::CAL_SAMPLES_DEFAULT,
    parameter int COUNT_BITS  = tkc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [COUNT_BITS-1:0]        cnt,
    input  logic [tkc_pkg::THR_W-1:0]    threshold,
    input  logic [tkc_pkg::HOLD_W-1:0]   hold_load,
    output tkc_pkg::tkc_lane_t           status
);
    import tkc_pkg::*;

    localparam int SAMPLE_W  = $clog2(CAL_SAMPLES + 1);
    localparam int DIV_SHIFT = $clog2(CAL_SAMPLES);
    localparam int RECIP_W   = COUNT_BITS + 2;
    localparam int PROD_W    = COUNT_BITS + RECIP_W + DIV_SHIFT;
    localparam int SUM_W     = COUNT_BITS + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << (COUNT_BITS + DIV_SHIFT)) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_LAST = SAMPLE_W'(CAL_SAMPLES);

    logic [COUNT_BITS-1:0] baseline_reg, baseline_next;
    logic [SAMPLE_W-1:0]   samples_reg, samples_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    logic [PROD_W-1:0]     prod;
    logic [COUNT_BITS-1:0] quot;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      bound;
    logic                  calibrating;
    logic                  touch;

    // exact divide by the sample count through a reciprocal multiply
    assign prod        = PROD_W'(cnt) * PROD_W'(RECIP);
    assign quot        = prod[COUNT_BITS+DIV_SHIFT +: COUNT_BITS];
    assign sum         = {1'b0, baseline_reg} + {1'b0, quot};
    assign bound       = {1'b0, baseline_reg} + SUM_W'(threshold);
    assign calibrating = samples_reg < SAMPLE_LAST;
    assign touch       = !calibrating && ({1'b0, cnt} > bound);

    assign status = '{cal: calibrating, touch: touch, idle: hold_reg == '0};

    always_comb begin
        baseline_next = baseline_reg;
        samples_next  = samples_reg;
        hold_next     = hold_reg;
        if (fire) begin
            if (calibrating) begin
                baseline_next = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
                samples_next  = samples_reg + 1'b1;
            end else if (touch) begin
                hold_next = hold_load;
            end else if (hold_reg != '0) begin
                hold_next = hold_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            samples_reg  <= '0;
            hold_reg     <= '0;
        end else begin
            baseline_reg <= baseline_next;
            samples_reg  <= samples_next;
            hold_reg     <= hold_next;
        end
    end

    a_samples_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        samples_reg <= SAMPLE_LAST)
        else $error("calibration sample count overran");

    a_no_hold_in_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_reg != '0) |-> !calibrating)
        else $error("hold counter loaded during calibration");

    a_baseline_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !calibrating |=> $stable(baseline_reg))
        else $error("baseline moved after calibration");

endmodule

>>> hdl/touch_key_controller.sv
// Top level of the touch key controller: input stage, key lanes, LED logic, result stage.
//
// Takes one discharge-time measurement per cycle on the s_ stream while s_tready is high
// and returns one result per measurement on the m_ stream. Sustained rate is one
// transaction per cycle while m_tready is held high: the measurement sits in an input
// register, the selected key lane does its reciprocal-multiply baseline update or its
// baseline-plus-threshold compare, and the LED, dimmer and result fields are registered
// in the same cycle. The result register frees the input side, so the next measurement
// is taken while a result waits. Each key calibrates on its first CAL_SAMPLES
// measurements; those results report calibrating and never touched. The user must put
// configuration on the APB port only while no transaction is in flight; not enforced.
module touch_key_controller #(
    parameter int KEYS        = tkc_pkg::KEYS_DEFAULT,
    parameter int CAL_SAMPLES = tkc_pkg::CAL_SAMPLES_DEFAULT,
    parameter int COUNT_BITS  = tkc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tkc_pkg::S_TDATA_W-1:0]   s_tdata,  // count
    input  logic [tkc_pkg::KEY_W-1:0]       s_tuser,  // key
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // momentary_led, toggle_led, timer_led, duty[7:0], calibrating, touched, 3'b0
    output logic [tkc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tkc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tkc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tkc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import tkc_pkg::*;

    tkc_cfg_t              cfg;
    tkc_lane_t             lane_st [KEY_SLOTS];
    tkc_lane_t             sel_st;
    logic [KEY_SLOTS-1:0]  hit;

    logic                  in_valid_reg, in_valid_next;
    logic [KEY_W-1:0]      key_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [LED_W-1:0]      led_reg, led_next;
    logic [LIDX_W-1:0]     level_reg, level_next;

    logic                  s_accept;
    logic                  out_ready;
    logic                  advance;
    logic [COUNT_BITS-1:0] cnt;
    logic [LEVEL_W-1:0]    lim;
    logic [LIDX_W-1:0]     step;
    logic [TABLE_W-1:0]    duty_shift;

    tkc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign cnt       = COUNT_BITS'(count_reg);

    for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_lane
        assign hit[k] = key_reg == KEY_W'(k);
        if (k < KEYS) begin : g_on
            tkc_lane #(
                .CAL_SAMPLES (CAL_SAMPLES),
                .COUNT_BITS  (COUNT_BITS)
            ) u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .fire      (advance && hit[k]),
                .cnt       (cnt),
                .threshold (cfg.threshold[k]),
                .hold_load ((k == KEY_TIMER) ? cfg.long_hold : cfg.short_hold),
                .status    (lane_st[k])
            );
        end else begin : g_off
            assign lane_st[k] = '0;
        end
    end

    assign sel_st = lane_st[key_reg];

    assign lim  = (cfg.level_count > LEVEL_W'(LEVELS)) ? LEVEL_W'(LEVELS) : cfg.level_count;
    assign step = level_reg + 1'b1;

    always_comb begin
        led_next   = led_reg;
        level_next = level_reg;
        if (advance) begin
            if (hit[KEY_MOMENTARY] && !lane_st[KEY_MOMENTARY].cal) begin
                if (lane_st[KEY_MOMENTARY].touch) begin
                    led_next[KEY_MOMENTARY] = 1'b1;
                end else if (lane_st[KEY_MOMENTARY].idle) begin
                    led_next[KEY_MOMENTARY] = 1'b0;
                end
            end
            if (hit[KEY_TIMER] && !lane_st[KEY_TIMER].cal) begin
                if (lane_st[KEY_TIMER].touch) begin
                    led_next[KEY_TIMER] = 1'b1;
                end else if (lane_st[KEY_TIMER].idle) begin
                    led_next[KEY_TIMER] = 1'b0;
                end
            end
            if (hit[KEY_TOGGLE] && lane_st[KEY_TOGGLE].touch && lane_st[KEY_TOGGLE].idle) begin
                led_next[KEY_TOGGLE] = !led_reg[KEY_TOGGLE];
            end
            if (hit[KEY_DIMMER] && lane_st[KEY_DIMMER].touch && lane_st[KEY_DIMMER].idle) begin
                level_next = ({1'b0, step} >= lim) ? '0 : step;
            end
        end
    end

    assign duty_shift = cfg.duty_table >> {level_next, 3'b000};

    always_comb begin
        m_data_next                                     = '0;
        m_data_next[OUT_MOM]                            = led_next[KEY_MOMENTARY];
        m_data_next[OUT_TOGGLE]                         = led_next[KEY_TOGGLE];
        m_data_next[OUT_TIMER]                          = led_next[KEY_TIMER];
        m_data_next[OUT_DUTY_LSB +: DUTY_W]             = duty_shift[DUTY_W-1:0];
        m_data_next[OUT_CAL]                            = sel_st.cal;
        m_data_next[OUT_TOUCH]                          = sel_st.touch;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            led_reg      <= '0;
            level_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            led_reg      <= led_next;
            level_reg    <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg   <= s_tuser;
            count_reg <= s_tdata;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cal_excludes_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[OUT_CAL] && m_data_reg[OUT_TOUCH]))
        else $error("result marked both calibrating and touched");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("input held off with room in the pipeline");

    a_leds_match_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_valid_reg && (m_data_reg[OUT_TIMER:OUT_MOM] == led_reg)))
        else $error("result LED fields differ from LED state");

    a_momentary_on_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit[KEY_MOMENTARY] && lane_st[KEY_MOMENTARY].touch)
            |=> led_reg[KEY_MOMENTARY])
        else $error("momentary LED not lit on touch");

endmodule
